FILE: hw/rtl/fnt_pkg.sv
// shared types, microcode fields and pitch tables for the frequency to note converter
`default_nettype none
package fnt_pkg;

   localparam int FREQ_W  = 24;
   localparam int NOTE_W  = 17;
   localparam int QUO_W   = 17;
   localparam int IDX_W   = 4;
   localparam int PC_W    = 4;
   localparam int CNT_W   = 5;
   localparam int LEVELS  = 4;
   // note = 8 octaves up minus the packed level indices
   localparam logic [NOTE_W-1:0] NOTE_BIAS = 17'd32768;

   typedef logic [PC_W-1:0]   pc_type;
   typedef logic [FREQ_W-1:0] entry_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_SEARCH,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_INPUT,
      COND_DIV_BUSY,
      COND_OUT_BUSY
   } cond_type;

   typedef enum logic [1:0] {
      LVL_OCTAVE,
      LVL_SEMI,
      LVL_FINE,
      LVL_XFINE
   } level_type;

   typedef struct packed {
      op_type    op;
      level_type level;
      cond_type  cond;
      pc_type    target;
   } uword_type;

   typedef struct packed {
      logic in_valid;
      logic out_busy;
      logic div_busy;
   } status_type;

   // program addresses used as jump targets
   localparam pc_type ST_WAIT  = 4'd0;
   localparam pc_type ST_DIV0  = 4'd3;
   localparam pc_type ST_DIV1  = 4'd6;
   localparam pc_type ST_DIV2  = 4'd9;
   localparam pc_type ST_EMIT  = 4'd11;

   localparam entry_type OCT_8363_ROM [16] = '{
      24'd13594045, 24'd5394801, 24'd2140928, 24'd849628,
      24'd337175,   24'd133808,  24'd53102,   24'd21073,
      24'd8363,     24'd3319,    24'd1317,    24'd523,
      24'd207,      24'd82,      24'd33,      24'd13};
   localparam entry_type OCT_6848_ROM [16] = '{
      24'd11131415, 24'd4417505, 24'd1753088, 24'd695713,
      24'd276094,   24'd109568,  24'd43482,   24'd17256,
      24'd6848,     24'd2718,    24'd1078,    24'd428,
      24'd170,      24'd67,      24'd27,      24'd11};
   localparam entry_type SEMI_ROM [16] = '{
      24'd32768, 24'd30929, 24'd29193, 24'd27554,
      24'd26008, 24'd24548, 24'd23170, 24'd21870,
      24'd20643, 24'd19484, 24'd18390, 24'd17358,
      24'd16384, 24'd15464, 24'd14596, 24'd13777};
   localparam entry_type FINE_ROM [16] = '{
      24'd32768, 24'd32650, 24'd32532, 24'd32415,
      24'd32298, 24'd32182, 24'd32066, 24'd31950,
      24'd31835, 24'd31720, 24'd31606, 24'd31492,
      24'd31379, 24'd31266, 24'd31153, 24'd31041};
   localparam entry_type XFINE_ROM [16] = '{
      24'd32768, 24'd32761, 24'd32753, 24'd32746,
      24'd32738, 24'd32731, 24'd32724, 24'd32716,
      24'd32709, 24'd32702, 24'd32694, 24'd32687,
      24'd32679, 24'd32672, 24'd32665, 24'd32657};

   function automatic entry_type tab_entry(input logic base, input level_type lvl,
                                           input logic [IDX_W-1:0] idx);
      entry_type entry;
      case (lvl)
         LVL_OCTAVE: entry = base ? OCT_6848_ROM[idx] : OCT_8363_ROM[idx];
         LVL_SEMI:   entry = SEMI_ROM[idx];
         LVL_FINE:   entry = FINE_ROM[idx];
         default:    entry = XFINE_ROM[idx];
      endcase
      return entry;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/fnt_sequencer.sv
// microcode rom, step counter and conditional jumps
`default_nettype none
module fnt_sequencer (
   input  wire                      clock,
   input  wire                      reset,
   input  wire fnt_pkg::status_type status,
   output fnt_pkg::uword_type       uword
);
   import fnt_pkg::*;

   pc_type pc_ff;
   pc_type pc_in;
   logic   jump;

   always_comb begin
      case (pc_ff)
         4'd0:    uword = '{OP_LOAD,     LVL_OCTAVE, COND_NO_INPUT, ST_WAIT};
         4'd1:    uword = '{OP_SEARCH,   LVL_OCTAVE, COND_NEVER,    ST_WAIT};
         4'd2:    uword = '{OP_DIV_INIT, LVL_OCTAVE, COND_NEVER,    ST_WAIT};
         4'd3:    uword = '{OP_DIV_STEP, LVL_OCTAVE, COND_DIV_BUSY, ST_DIV0};
         4'd4:    uword = '{OP_SEARCH,   LVL_SEMI,   COND_NEVER,    ST_WAIT};
         4'd5:    uword = '{OP_DIV_INIT, LVL_SEMI,   COND_NEVER,    ST_WAIT};
         4'd6:    uword = '{OP_DIV_STEP, LVL_SEMI,   COND_DIV_BUSY, ST_DIV1};
         4'd7:    uword = '{OP_SEARCH,   LVL_FINE,   COND_NEVER,    ST_WAIT};
         4'd8:    uword = '{OP_DIV_INIT, LVL_FINE,   COND_NEVER,    ST_WAIT};
         4'd9:    uword = '{OP_DIV_STEP, LVL_FINE,   COND_DIV_BUSY, ST_DIV2};
         4'd10:   uword = '{OP_SEARCH,   LVL_XFINE,  COND_NEVER,    ST_WAIT};
         4'd11:   uword = '{OP_EMIT,     LVL_XFINE,  COND_OUT_BUSY, ST_EMIT};
         default: uword = '{OP_NOP,      LVL_OCTAVE, COND_ALWAYS,   ST_WAIT};
      endcase
   end

   always_comb begin
      case (uword.cond)
         COND_NEVER:    jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_INPUT: jump = !status.in_valid;
         COND_DIV_BUSY: jump = status.div_busy;
         COND_OUT_BUSY: jump = status.out_busy;
         default:       jump = 1'b1;
      endcase
      pc_in = jump ? uword.target : pc_type'(pc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/fnt_datapath.sv
// value register, table search and restoring divider driven by the control word
`default_nettype none
module fnt_datapath (
   input  wire                          clock,
   input  wire                          reset,
   input  wire fnt_pkg::uword_type      uword,
   input  wire                          in_valid,
   input  wire                          base_select,
   input  wire [fnt_pkg::FREQ_W-1:0]    frequency,
   output logic                         div_busy,
   output logic [fnt_pkg::NOTE_W-1:0]   note
);
   import fnt_pkg::*;

   logic [FREQ_W-1:0]        v_ff, v_in;
   entry_type                divisor_ff, divisor_in;
   logic [FREQ_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]         qd_ff, qd_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [IDX_W*LEVELS-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]         idx_found;
   logic [FREQ_W+1:0]        trial;

   // first index whose next entry lies below the value, else the last one
   always_comb begin
      idx_found = 4'd15;
      for (int k = 14; k >= 0; k--) begin
         if (tab_entry(base_select, uword.level, IDX_W'(k + 1)) < v_ff) begin
            idx_found = IDX_W'(k);
         end
      end
   end

   assign trial = {1'b0, rem_ff, qd_ff[QUO_W-1]} - {2'b00, divisor_ff};

   always_comb begin
      v_in       = v_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      qd_in      = qd_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      case (uword.op)
         OP_LOAD: begin
            if (in_valid) begin
               v_in = frequency;
            end
         end
         OP_SEARCH: begin
            idx_in     = {idx_ff[IDX_W*(LEVELS-1)-1:0], idx_found};
            divisor_in = tab_entry(base_select, uword.level, idx_found);
         end
         OP_DIV_INIT: begin
            // value * 32768 has its top bits preloaded, the quotient fits 17 bits
            rem_in = {2'b00, v_ff[FREQ_W-1:2]};
            qd_in  = {v_ff[1:0], 15'd0};
            cnt_in = CNT_W'(QUO_W - 1);
         end
         OP_DIV_STEP: begin
            if (!trial[FREQ_W+1]) begin
               rem_in = trial[FREQ_W-1:0];
               qd_in  = {qd_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[FREQ_W-2:0], qd_ff[QUO_W-1]};
               qd_in  = {qd_ff[QUO_W-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               v_in = {{(FREQ_W-QUO_W){1'b0}}, qd_in};
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      v_ff       <= v_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      qd_ff      <= qd_in;
      idx_ff     <= idx_in;
   end

   assign div_busy = (cnt_ff != '0);
   // packed indices weigh 4096, 256, 16, 1; octave offset folds into the bias
   assign note     = NOTE_BIAS - {1'b0, idx_ff};

endmodule
`default_nettype wire

FILE: hw/rtl/frequency_to_note_top.sv
// frequency to note converter: handshakes, config register and output register
// one transaction in flight at a time; the microcode program sets the timing
// after acceptance the program searches and divides at the octave, semitone and fine levels
// with three bit-serial divisions, then searches the extra-fine level and emits the result
// each table level search is a combinational table scan; the result waits in an output register
// reset: synchronous; program returns to the accept step, base_select clears to 0
`default_nettype none
module frequency_to_note_top (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [fnt_pkg::FREQ_W-1:0]        req_frequency,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic signed [fnt_pkg::NOTE_W-1:0] rsp_note_value,
   input  wire                               csr_write_enable,
   input  wire                               csr_write_data
);
   import fnt_pkg::*;

   uword_type             uword;
   status_type            status;
   logic                  div_busy;
   logic [NOTE_W-1:0]     note;
   logic                  base_select_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [NOTE_W-1:0]     rsp_note_ff, rsp_note_in;
   logic                  out_busy;
   logic                  rsp_load;

   assign out_busy = rsp_valid_ff && rsp_stall;
   assign status   = '{in_valid: req_valid, out_busy: out_busy, div_busy: div_busy};

   fnt_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .uword  (uword)
   );

   fnt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .uword       (uword),
      .in_valid    (req_valid),
      .base_select (base_select_ff),
      .frequency   (req_frequency),
      .div_busy    (div_busy),
      .note        (note)
   );

   assign req_stall = (uword.op != OP_LOAD);
   assign rsp_load  = (uword.op == OP_EMIT) && !out_busy;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_note_in  = rsp_note_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_note_in  = note;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         base_select_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            base_select_ff <= csr_write_data;
         end
      end
      rsp_note_ff <= rsp_note_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_note_value = $signed(rsp_note_ff);

   // a transaction is taken only when the program sits at its accept step
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while a conversion is running");

   a_div_in_step: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (uword.op == OP_DIV_STEP))
      else $error("divider count live outside a divide step");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(uword.op == OP_EMIT))
      else $error("result appeared without an emit step");

endmodule
`default_nettype wire

FILE: verif/frequency_to_note_top_test.sv
// self-checking testbench for the frequency to note converter
`timescale 1ns / 1ps
module frequency_to_note_top_test;
   import fnt_pkg::*;

   localparam logic BASE_8363 = 1'b0;
   localparam logic BASE_6848 = 1'b1;
   localparam int   WATCHDOG_LIMIT = 4000;
   localparam int   SETTLE_CYCLES  = 80;
   localparam int   RANDOM_PER_PHASE = 450;

   typedef struct {
      logic [FREQ_W-1:0] frequency;
      logic              base;
      logic [NOTE_W-1:0] note;
   } pitch_expect_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [FREQ_W-1:0] req_frequency = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [NOTE_W-1:0] rsp_note_value;
   logic csr_write_enable = 1'b0;
   logic csr_write_data = 1'b0;

   int unsigned octave_8363 [16] = '{
      13594045, 5394801, 2140928, 849628, 337175, 133808, 53102, 21073,
      8363, 3319, 1317, 523, 207, 82, 33, 13};
   int unsigned octave_6848 [16] = '{
      11131415, 4417505, 1753088, 695713, 276094, 109568, 43482, 17256,
      6848, 2718, 1078, 428, 170, 67, 27, 11};
   int unsigned semitone_steps [16] = '{
      32768, 30929, 29193, 27554, 26008, 24548, 23170, 21870,
      20643, 19484, 18390, 17358, 16384, 15464, 14596, 13777};
   int unsigned fine_steps [16] = '{
      32768, 32650, 32532, 32415, 32298, 32182, 32066, 31950,
      31835, 31720, 31606, 31492, 31379, 31266, 31153, 31041};
   int unsigned xfine_steps [16] = '{
      32768, 32761, 32753, 32746, 32738, 32731, 32724, 32716,
      32709, 32702, 32694, 32687, 32679, 32672, 32665, 32657};

   pitch_expect_type expected_pitches [$];
   logic base_shadow = BASE_8363;
   int   mismatch_count = 0;
   int   idle_pct = 0;
   int   stall_pct = 0;
   int   quiet_cycles = 0;

   frequency_to_note_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frequency    (req_frequency),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_note_value   (rsp_note_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned pitch_step(input logic base, input int lvl, input int idx);
      int unsigned step;
      case (lvl)
         0:       step = base ? octave_6848[idx] : octave_8363[idx];
         1:       step = semitone_steps[idx];
         2:       step = fine_steps[idx];
         default: step = xfine_steps[idx];
      endcase
      return step;
   endfunction

   function automatic logic [NOTE_W-1:0] predict_note(input logic [FREQ_W-1:0] freq,
                                                     input logic base);
      longint unsigned value;
      int idx;
      int sum;
      int weight;
      logic [31:0] negated;
      value = longint'(freq);
      sum = 0;
      for (int lvl = 0; lvl < 4; lvl++) begin
         idx = 0;
         // first entry whose successor falls below the running value
         while (idx < 15 && !(longint'(pitch_step(base, lvl, idx + 1)) < value))
            idx++;
         weight = (lvl == 0) ? 4096 : (lvl == 1) ? 256 : (lvl == 2) ? 16 : 1;
         sum += ((lvl == 0) ? idx - 8 : idx) * weight;
         value = (value * 64'd32768) / longint'(pitch_step(base, lvl, idx));
      end
      negated = -sum;
      return negated[NOTE_W-1:0];
   endfunction

   function automatic logic [FREQ_W-1:0] random_frequency(input logic base);
      int mode;
      int k;
      longint near_value;
      logic [FREQ_W-1:0] freq;
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
         // spread over octaves by picking a random magnitude first
         k = $urandom_range(0, FREQ_W);
         freq = FREQ_W'($urandom & ((32'd1 << k) - 1));
      end else if (mode <= 7) begin
         near_value = longint'(pitch_step(base, 0, $urandom_range(0, 15)))
                      + $urandom_range(0, 4) - 2;
         freq = FREQ_W'(near_value);
      end else if (mode == 8) begin
         freq = FREQ_W'($urandom);
      end else begin
         freq = FREQ_W'($urandom_range(0, 32));
      end
      return freq;
   endfunction

   task automatic report_mismatch(input string what, input logic [FREQ_W-1:0] freq,
                                  input logic [NOTE_W-1:0] want,
                                  input logic [NOTE_W-1:0] got);
      if (mismatch_count < 100)
         $display("mismatch: %s freq %0d expected %0d got %0d", what, freq,
                  $signed(want), $signed(got));
      mismatch_count++;
   endtask

   // called at a falling edge, returns at a falling edge after the transaction
   task automatic send_frequency(input logic [FREQ_W-1:0] freq);
      pitch_expect_type item;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_frequency = freq;
      do @(posedge clock); while (req_stall !== 1'b0);
      item.frequency = freq;
      item.base = base_shadow;
      item.note = predict_note(freq, base_shadow);
      expected_pitches.push_back(item);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (expected_pitches.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_base_select(input logic base);
      drain_results();
      csr_write_enable = 1'b1;
      csr_write_data = base;
      @(negedge clock);
      csr_write_enable = 1'b0;
      base_shadow = base;
   endtask

   task automatic test_reset_default();
      logic [FREQ_W-1:0] freqs [12] = '{
         24'd0, 24'd1, 24'd12, 24'd13, 24'd14, 24'd8363, 24'd8364, 24'd21073,
         24'd13594044, 24'd13594045, 24'd13594046, 24'hFFFFFF};
      foreach (freqs[i])
         send_frequency(freqs[i]);
   endtask

   task automatic test_base_6848();
      logic [FREQ_W-1:0] freqs [12] = '{
         24'd0, 24'd10, 24'd11, 24'd12, 24'd6848, 24'd6847, 24'd11131414,
         24'd11131415, 24'd11131416, 24'h555555, 24'hAAAAAA, 24'hFFFFFF};
      write_base_select(BASE_6848);
      foreach (freqs[i])
         send_frequency(freqs[i]);
   endtask

   task automatic test_random_traffic();
      int idle_set [4] = '{0, 76, 0, 26};
      int stall_set [4] = '{0, 0, 76, 26};
      for (int phase = 0; phase < 4; phase++) begin
         for (int half = 0; half < 2; half++) begin
            write_base_select((phase + half) % 2 == 0 ? BASE_8363 : BASE_6848);
            idle_pct = idle_set[phase];
            stall_pct = stall_set[phase];
            for (int n = 0; n < RANDOM_PER_PHASE / 2; n++)
               send_frequency(random_frequency(base_shadow));
         end
      end
      idle_pct = 0;
      stall_pct = 0;
   endtask

   always @(negedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   always @(posedge clock) begin
      pitch_expect_type item;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_pitches.size() == 0) begin
            report_mismatch("unexpected transaction", '0, '0, rsp_note_value);
         end else begin
            item = expected_pitches.pop_front();
            if (rsp_note_value !== item.note)
               report_mismatch(item.base ? "base 6848" : "base 8363", item.frequency,
                               item.note, rsp_note_value);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_default();
      test_base_6848();
      test_random_traffic();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/fnt_pkg.sv
hw/rtl/fnt_sequencer.sv
hw/rtl/fnt_datapath.sv
hw/rtl/frequency_to_note_top.sv
verif/frequency_to_note_top_test.sv
